>>> src/tsd_pkg.sv
// Shared types and constants for the timestamp delta stream decoder.
// No dependencies; used by the decoder core, the result queue and the top level.
package tsd_pkg;

  // default configuration
  localparam int StampWidthDef  = 64;
  localparam int HeaderBytesDef = 8;

  // fixed field widths
  localparam int ByteW  = 8;
  localparam int DeltaW = 28;
  localparam int OutW   = 64;

  // record prefix values (lead byte bits [7:6])
  localparam logic [1:0] PFX_INLINE = 2'd0;

  // bit pair codes of an inline lead byte
  localparam logic [1:0] PAIR_BUMP   = 2'd1;
  localparam logic [1:0] PAIR_REPEAT = 2'd2;

  // marker codes in the top bits of the last extension byte
  localparam logic [1:0] MRK_NONE = 2'd0;
  localparam logic [1:0] MRK_REP1 = 2'd1;
  localparam logic [1:0] MRK_BUMP = 2'd2;
  localparam logic [1:0] MRK_REP2 = 2'd3;

  // stamps caused by one byte: count and per-stamp offset from a shared base
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][1:0] off;
  } burst_t;

endpackage

>>> src/timestamp_delta_stream_decoder.sv
// A stamp passes the burst buffer and then the output register before out_tvalid rises, and
// out_tready low can hold it in the buffer.
// Throughput: one byte per cycle while each byte yields one stamp or none; a byte that yields
// several stamps holds the input until its last stamp is popped; out_tready low holds the input.
// Reset: rst_n is synchronous and active low; it returns the decoder to the header phase.
// Top level of the timestamp delta stream decoder; depends on tsd_pkg, tsd_decode, tsd_outq.
module timestamp_delta_stream_decoder #(
  parameter int STAMP_WIDTH  = tsd_pkg::StampWidthDef,
  parameter int HEADER_BYTES = tsd_pkg::HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] new_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] timestamp
  output logic        out_tlast   // last_of_run
);

  logic                   take;
  logic                   room;
  tsd_pkg::burst_t        burst;
  logic [STAMP_WIDTH-1:0] burst_base;

  // input beat
  assign take      = in_tvalid && room;
  assign in_tready = room;

  tsd_decode #(
    .STAMP_WIDTH  (STAMP_WIDTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_tdata),
    .new_stream (in_tuser),
    .burst      (burst),
    .burst_base (burst_base)
  );

  tsd_outq #(
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && (burst.cnt != 2'd0)),
    .burst      (burst),
    .burst_base (burst_base),
    .room       (room),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_stamp  (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

>>> src/tsd_decode.sv
// Byte decoder core: header assembly, record parsing and running stamp.
// Depends on tsd_pkg. Emits a burst description for each accepted byte.
module tsd_decode #(
  parameter int STAMP_WIDTH  = tsd_pkg::StampWidthDef,
  parameter int HEADER_BYTES = tsd_pkg::HeaderBytesDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  logic [7:0]              data_byte,
  input  logic                    new_stream,
  output tsd_pkg::burst_t         burst,
  output logic [STAMP_WIDTH-1:0]  burst_base
);

  localparam int HW   = $clog2(HEADER_BYTES + 1);
  localparam int SUMW = tsd_pkg::DeltaW + 1;

  // running stamp is kept as base plus a small pending increment
  logic [HW-1:0]               hdr_cnt_r, hdr_cnt_nxt;
  logic [STAMP_WIDTH-1:0]      base_r, base_nxt;
  logic [1:0]                  pend_r, pend_nxt;
  logic [1:0]                  ext_left_r, ext_left_nxt;
  logic [1:0]                  ext_idx_r, ext_idx_nxt;
  logic [tsd_pkg::DeltaW-1:0]  delta_r, delta_nxt;

  // decode of one byte
  always_comb begin
    logic [HW-1:0]              hdr_e;
    logic [STAMP_WIDTH-1:0]     base_e;
    logic [1:0]                 pend_e;
    logic [1:0]                 left_e;
    logic [1:0]                 idx_e;
    logic [tsd_pkg::DeltaW-1:0] delta_e;
    logic [tsd_pkg::DeltaW-1:0] delta_full;
    logic [tsd_pkg::DeltaW-1:0] v_ext;
    logic [4:0]                 sh;
    logic [SUMW-1:0]            addend;
    logic [1:0]                 cur;
    logic [1:0]                 n;
    logic [1:0]                 code;
    logic [1:0]                 marker;
    logic                       emit_rec;

    // a new stream restarts from the reset state
    hdr_e   = new_stream ? '0 : hdr_cnt_r;
    base_e  = new_stream ? '0 : base_r;
    pend_e  = new_stream ? 2'd0 : pend_r;
    left_e  = new_stream ? 2'd0 : ext_left_r;
    idx_e   = new_stream ? 2'd0 : ext_idx_r;
    delta_e = new_stream ? '0 : delta_r;

    hdr_cnt_nxt  = hdr_e;
    base_nxt     = base_e;
    pend_nxt     = pend_e;
    ext_left_nxt = left_e;
    ext_idx_nxt  = idx_e;
    delta_nxt    = delta_e;
    burst        = '0;
    emit_rec     = 1'b0;
    addend       = '0;
    cur          = 2'd0;
    n            = 2'd0;
    code         = 2'd0;
    marker       = 2'd0;
    sh           = 5'd0;
    v_ext        = '0;
    delta_full   = '0;

    if (hdr_e < HW'(HEADER_BYTES)) begin
      // header byte shifts in from the low end
      base_nxt    = {base_e[STAMP_WIDTH-9:0], data_byte};
      hdr_cnt_nxt = hdr_e + HW'(1);
      if (hdr_cnt_nxt == HW'(HEADER_BYTES)) begin
        burst.cnt = 2'd1;
      end
    end else if (left_e == 2'd0) begin
      if (data_byte[7:6] == tsd_pkg::PFX_INLINE) begin
        // inline record: optional +1, then two pair codes
        emit_rec = 1'b1;
        addend   = SUMW'(pend_e) + SUMW'(data_byte[5]);
        n        = 2'd1;
        for (int k = 1; k >= 0; k--) begin
          code = data_byte[2*k +: 2];
          if (code == tsd_pkg::PAIR_REPEAT) begin
            burst.off[n] = cur;
            n = n + 2'd1;
          end else if (code == tsd_pkg::PAIR_BUMP) begin
            cur = cur + 2'd1;
            burst.off[n] = cur;
            n = n + 2'd1;
          end
        end
        burst.cnt = n;
        pend_nxt  = cur;
      end else begin
        // long record: lead bits open the delta
        ext_left_nxt = data_byte[7:6];
        ext_idx_nxt  = 2'd0;
        delta_nxt    = tsd_pkg::DeltaW'(data_byte[5:0]);
      end
    end else begin
      // extension byte, low byte first
      if (left_e == 2'd1) begin
        marker = data_byte[7:6];
        v_ext  = tsd_pkg::DeltaW'(data_byte[5:0]);
      end else begin
        v_ext  = tsd_pkg::DeltaW'(data_byte);
      end
      sh           = 5'd6 + {idx_e, 3'b000};
      delta_full   = delta_e | (v_ext << sh);
      delta_nxt    = delta_full;
      ext_idx_nxt  = idx_e + 2'd1;
      ext_left_nxt = left_e - 2'd1;
      if (left_e == 2'd1) begin
        emit_rec    = 1'b1;
        addend      = SUMW'(pend_e) + SUMW'(delta_full);
        delta_nxt   = '0;
        ext_idx_nxt = 2'd0;
        pend_nxt    = 2'd0;
        case (marker)
          tsd_pkg::MRK_NONE: burst.cnt = 2'd1;
          tsd_pkg::MRK_REP1: burst.cnt = 2'd2;
          tsd_pkg::MRK_REP2: burst.cnt = 2'd3;
          tsd_pkg::MRK_BUMP: begin
            burst.cnt    = 2'd2;
            burst.off[1] = 2'd1;
            pend_nxt     = 2'd1;
          end
          default: burst.cnt = 2'd1;
        endcase
      end
    end

    // one wide add folds the pending increment and the delta into the base
    if (emit_rec) begin
      base_nxt = base_e + STAMP_WIDTH'(addend);
    end

    burst_base = base_nxt;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      base_r     <= '0;
      pend_r     <= 2'd0;
      ext_left_r <= 2'd0;
      ext_idx_r  <= 2'd0;
      delta_r    <= '0;
    end else if (take) begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      base_r     <= base_nxt;
      pend_r     <= pend_nxt;
      ext_left_r <= ext_left_nxt;
      ext_idx_r  <= ext_idx_nxt;
      delta_r    <= delta_nxt;
    end
  end

endmodule

>>> src/tsd_outq.sv
// Result queue: holds the stamps of one byte and drains them one per beat.
// Depends on tsd_pkg. Feeds the output register of the result channel.
module tsd_outq #(
  parameter int STAMP_WIDTH = tsd_pkg::StampWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  tsd_pkg::burst_t              burst,
  input  logic [STAMP_WIDTH-1:0]       burst_base,
  output logic                         room,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tsd_pkg::OutW-1:0]     out_stamp,
  output logic                         out_last
);

  logic [STAMP_WIDTH-1:0]    buf_base_r;
  logic [2:0][1:0]           buf_off_r;
  logic [1:0]                buf_rem_r, buf_rem_nxt;
  logic                      out_valid_r;
  logic [tsd_pkg::OutW-1:0]  out_stamp_r;
  logic                      out_last_r;
  logic                      pop;

  // move the next stamp into the output register when it is free
  assign pop  = (buf_rem_r != 2'd0) && (!out_valid_r || out_ready);
  assign room = (buf_rem_r == 2'd0) || ((buf_rem_r == 2'd1) && pop);

  always_comb begin
    buf_rem_nxt = buf_rem_r;
    if (load) begin
      buf_rem_nxt = burst.cnt;
    end else if (pop) begin
      buf_rem_nxt = buf_rem_r - 2'd1;
    end
  end

  // burst buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_rem_r <= 2'd0;
    end else begin
      buf_rem_r <= buf_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_base_r <= burst_base;
      buf_off_r  <= burst.off;
    end else if (pop) begin
      buf_off_r  <= {2'd0, buf_off_r[2], buf_off_r[1]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_stamp_r <= tsd_pkg::OutW'(buf_base_r + STAMP_WIDTH'(buf_off_r[0]));
      out_last_r  <= (buf_rem_r == 2'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_stamp = out_stamp_r;
  assign out_last  = out_last_r;

endmodule

>>> src/tsd_checker.sv
// Port-level checks for the timestamp delta stream decoder.
// Depends only on the top level's ports; bound to it below.
module tsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // a run continues without a bubble until its last beat
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run of stamps");

  // input is held back only while stamps are pending for output
  a_stall_why: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> out_tvalid)
    else $error("input stalled with no stamp on the way");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the decoder");

endmodule

bind timestamp_delta_stream_decoder tsd_checker u_tsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/timestamp_delta_stream_decoder_tb.sv
// Testbench for timestamp_delta_stream_decoder: sends encoded byte streams with random gaps
// and checks every decoded stamp against a scoreboard that decodes the same bytes.
// Depends on tsd_pkg and the decoder RTL.
module timestamp_delta_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HdrBytes    = tsd_pkg::HeaderBytesDef;
  localparam int RandItems   = 200;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 24;

  typedef struct {
    logic [tsd_pkg::OutW-1:0] stamp;
    logic                     last;
  } stamp_beat_t;

  // decodes accepted bytes and holds the stamps still due from the block
  class stamp_scoreboard;
    int                         hdr_seen;
    logic [tsd_pkg::OutW-1:0]   stamp;
    logic [1:0]                 ext_left;
    logic [1:0]                 ext_idx;
    logic [tsd_pkg::DeltaW-1:0] delta;
    stamp_beat_t                due[$];
    int                         errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      hdr_seen = 0;
      stamp    = '0;
      ext_left = '0;
      ext_idx  = '0;
      delta    = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic ns);
      logic [tsd_pkg::OutW-1:0] run[$];
      logic [1:0]               pairs[2];
      logic [1:0]               marker;
      logic [7:0]               v;
      bit                       closing;
      stamp_beat_t              beat;
      if (ns) restart();
      if (hdr_seen < HdrBytes) begin
        // header bytes shift in big-endian, base goes out once complete
        stamp = {stamp[tsd_pkg::OutW-9:0], b};
        hdr_seen++;
        if (hdr_seen >= HdrBytes) run.push_back(stamp);
      end else if (ext_left == 0) begin
        if (b[7:6] == tsd_pkg::PFX_INLINE) begin
          // inline record: optional +1, one stamp, then two bit pair actions
          if (b[5]) stamp = stamp + 1;
          run.push_back(stamp);
          pairs[0] = b[3:2];
          pairs[1] = b[1:0];
          foreach (pairs[i]) begin
            if (pairs[i] == tsd_pkg::PAIR_REPEAT) begin
              run.push_back(stamp);
            end else if (pairs[i] == tsd_pkg::PAIR_BUMP) begin
              stamp = stamp + 1;
              run.push_back(stamp);
            end
          end
        end else begin
          ext_left = b[7:6];
          ext_idx  = '0;
          delta    = tsd_pkg::DeltaW'(b[5:0]);
        end
      end else begin
        // extension byte, the last one carries a marker in its top bits
        closing = (ext_left == 2'd1);
        v       = b;
        marker  = tsd_pkg::MRK_NONE;
        if (closing) begin
          marker = b[7:6];
          v      = {2'b00, b[5:0]};
        end
        delta    = delta | (tsd_pkg::DeltaW'(v) << (6 + 8 * ext_idx));
        ext_idx  = ext_idx + 2'd1;
        ext_left = ext_left - 2'd1;
        if (closing) begin
          stamp = stamp + tsd_pkg::OutW'(delta);
          run.push_back(stamp);
          case (marker)
            tsd_pkg::MRK_REP1: begin
              run.push_back(stamp);
            end
            tsd_pkg::MRK_REP2: begin
              run.push_back(stamp);
              run.push_back(stamp);
            end
            tsd_pkg::MRK_BUMP: begin
              stamp = stamp + 1;
              run.push_back(stamp);
            end
            default: ;
          endcase
          delta   = '0;
          ext_idx = '0;
        end
      end
      foreach (run[i]) begin
        beat.stamp = run[i];
        beat.last  = (i == run.size() - 1);
        due.push_back(beat);
      end
    endfunction

    function void check_stamp(logic [tsd_pkg::OutW-1:0] ts, logic last);
      stamp_beat_t beat;
      if (due.size() == 0) begin
        $display("%0t: unexpected stamp, expected none, actual %h last %b", $time, ts, last);
        errors++;
      end else begin
        beat = due.pop_front();
        if (ts !== beat.stamp) begin
          $display("%0t: timestamp mismatch, expected %h, actual %h", $time, beat.stamp, ts);
          errors++;
        end
        if (last !== beat.last) begin
          $display("%0t: last_of_run mismatch, expected %b, actual %b", $time, beat.last, last);
          errors++;
        end
      end
    endfunction

    function void close_out();
      foreach (due[i])
        $display("%0t: missing stamp, expected %h last %b, actual none", $time,
                 due[i].stamp, due[i].last);
      errors += due.size();
    endfunction
  endclass

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = '0;
  logic                     in_tuser   = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [tsd_pkg::OutW-1:0] out_tdata;
  logic                     out_tlast;

  stamp_scoreboard sb = new();
  bit              in_steady  = 1'b0;
  int              sent       = 0;
  int              idle_cycles = 0;

  timestamp_delta_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // one byte beat, after a random gap unless in a steady stretch
  task automatic send_byte(input logic [7:0] b, input logic ns);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= ns;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, ns);
    sent++;
  endtask

  task automatic send_header(input logic [tsd_pkg::OutW-1:0] base, input logic mark);
    for (int i = 0; i < HdrBytes; i++)
      send_byte(base[tsd_pkg::OutW-1-8*i -: 8], mark && (i == 0));
  endtask

  // well-formed record with random content
  task automatic send_record();
    logic [1:0] pfx;
    logic [7:0] b;
    pfx    = 2'($urandom_range(0, 3));
    b      = 8'($urandom);
    b[7:6] = pfx;
    send_byte(b, 1'b0);
    repeat (pfx) send_byte(8'($urandom), 1'b0);
  endtask

  // result side: random stalls, with steady stretches
  initial begin
    int stall;
    bit out_steady;
    out_steady = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_stamp(out_tdata, out_tlast);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [tsd_pkg::OutW-1:0] base;
    int                       kind;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // header with no start mark, base near the top so deltas wrap
    send_header(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    // zero lead, no-op pairs, repeats, bump then repeat, repeat then bump
    send_byte(8'h00, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h2A, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h09, 1'b0);
    // largest delta with two repeats
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // one extension byte with bump marker, two with one repeat
    send_byte(8'h40, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h40, 1'b0);
    // restart in the middle of an open record
    send_byte(8'hC5, 1'b0);
    send_byte(8'h11, 1'b0);
    send_header(64'h0, 1'b1);

    // random part: mostly records, some fresh headers and stray bytes
    sent = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 9) == 0) in_steady = !in_steady;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        base = {$urandom, $urandom};
        if (kind < 2) base[tsd_pkg::OutW-1:8] = '1;
        send_header(base, 1'b1);
      end else if (kind < 12) begin
        send_byte(8'($urandom), 1'($urandom));
      end else begin
        send_record();
      end
    end
    in_tvalid <= 1'b0;

    // drain and settle
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
